// ===== sv/rfce_pkg.sv =====
package rfce_pkg;

  localparam int unsigned CoeffCount = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 63;

  localparam logic [CfgIdxW-1:0] RegNumConst  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNumLinear = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDenSquare = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDenLinear = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDenConst  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPrecision = 3'd5;

  localparam logic [62:0] Max63 = {63{1'b1}};

  // Numerator magnitude below 2^49, shifted by 16 -> 65-bit dividend.
  localparam int unsigned DivNumW = 65;
  localparam int unsigned DivDenW = 66;
  localparam int unsigned DivCntW = 7;

  typedef struct packed {
    logic [62:0] cost;
    logic        improved;
    logic        done_res;
    logic        saturated;
  } rfce_res_t;

endpackage

// ===== sv/rfce_if.sv =====
interface rfce_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_x;
  logic [31:0] sample_y;
  logic        last_sample;
  modport source (output valid, sample_x, sample_y, last_sample, input ready);
  modport sink (input valid, sample_x, sample_y, last_sample, output ready);
endinterface

interface rfce_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] cost;
  logic        improved;
  logic        done_res;
  logic        saturated;
  modport source (output valid, cost, improved, done_res, saturated, input ready);
  modport sink (input valid, cost, improved, done_res, saturated, output ready);
endinterface

// ===== sv/rfce_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module rfce_divider import rfce_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivNumW-1:0]  num_i,
  input  logic [DivDenW-1:0]  den_i,
  output logic                fin_o,
  output logic [DivNumW-1:0]  quo_o
);

  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d, den_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, fin_q, fin_d;
  logic [DivDenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    trial  = {rem_q, quo_q[DivNumW-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = DivCntW'(DivNumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivDenW]) begin
        rem_d = trial[DivDenW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivDenW-2:0], quo_q[DivNumW-1]};
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign fin_o  = fin_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/rfce_mac.sv =====
// Shift-add multiplier: 2-bit digit of the multiplier per cycle, 33x33 signed.
module rfce_mac import rfce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic               fin_o,
  output logic signed [63:0] p_o
);

  logic [32:0] mb_q;
  logic [63:0] ma_q;
  logic [63:0] acc_q;
  logic        neg_q, busy_q, fin_q;
  logic [4:0]  cnt_q;
  logic [32:0] amag, bmag;
  logic [63:0] addend;

  assign amag = a_i[32] ? 33'(-a_i) : a_i;
  assign bmag = b_i[32] ? 33'(-b_i) : b_i;
  assign addend = (mb_q[0] ? ma_q : 64'd0) + (mb_q[1] ? {ma_q[62:0], 1'b0} : 64'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= {31'd0, amag};
      mb_q  <= bmag;
      acc_q <= '0;
      neg_q <= a_i[32] ^ b_i[32];
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
      ma_q  <= {ma_q[61:0], 2'b00};
      mb_q  <= {2'b00, mb_q[32:2]};
    end
  end

  assign fin_o = fin_q;
  assign p_o   = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// ===== sv/rational_fit_cost_evaluator_top.sv =====
// Rational fit cost evaluator. Scores y = (b0 + b1*x) / (a0 + a1*x + a2*x^2)
// against a stream of Q16.16 samples, adding each squared error into a
// saturating Q31.32 sum; the word flagged last_sample yields one result word
// with the cost, improvement, done and saturation flags. One sample is in
// flight at a time. Each sample runs six 33x33 products on one shared
// 2-bit-per-cycle multiplier plus a restoring divider that produces one
// quotient bit per cycle; a zero denominator or a huge quotient or error
// skips the remaining work. A result word waits in an output register;
// the next sample is accepted meanwhile. Coefficients and the precision
// limit are written through the cfg port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module rational_fit_cost_evaluator_top import rfce_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rfce_in_if.sink             in_if,
  rfce_out_if.source          out_if
);

  typedef enum logic [3:0] {
    StIdle, StXsq, StB1x, StA1x, StA2hi, StA2lo, StDen, StDiv, StErr, StSq, StAcc, StRes
  } state_e;

  state_e state_q;
  logic signed [31:0] coef_q [CoeffCount];
  logic signed [31:0] best_coef_q [CoeffCount];
  logic [62:0] limit_q, err_sum_q, best_q;
  logic        done_q, sat_q;
  logic signed [31:0] x_q, y_q;
  logic        last_q;
  logic [46:0] xsq_q;
  logic signed [49:0] num_q;
  logic signed [63:0] den_q;
  logic signed [63:0] err_q;
  logic [63:0] sq_q;
  logic        out_valid_q;
  rfce_res_t   res_q;

  logic               m_start, m_fin;
  logic signed [32:0] m_a, m_b;
  logic signed [63:0] m_p;
  logic               div_start, div_fin;
  logic [DivNumW-1:0] quo;
  logic [48:0]        nmag;
  logic [63:0]        dmag;
  logic signed [63:0] fl16;
  logic [63:0]        emag;
  logic [63:0]        sum;

  assign fl16 = m_p >>> 16;
  assign nmag = num_q[49] ? 49'(-num_q) : 49'(num_q);
  assign dmag = den_q[63] ? 64'(-den_q) : 64'(den_q);
  assign emag = err_q[63] ? 64'(-err_q) : 64'(err_q);
  assign sum  = {1'b0, err_sum_q} + sq_q;

  always_comb begin
    m_a = 33'(x_q);
    m_b = 33'(x_q);
    case (state_q)
      StB1x:  m_a = 33'(coef_q[RegNumLinear]);
      StA1x:  m_a = 33'(coef_q[RegDenLinear]);
      StA2hi: begin
        m_a = 33'(coef_q[RegDenSquare]);
        m_b = $signed({2'b00, xsq_q[46:16]});
      end
      StA2lo: begin
        m_a = 33'(coef_q[RegDenSquare]);
        m_b = $signed({17'd0, xsq_q[15:0]});
      end
      // |err| may reach 2^32-1; square it as an unsigned magnitude
      StSq:   begin m_a = $signed({1'b0, err_q[31:0]}); m_b = $signed({1'b0, err_q[31:0]}); end
      default: ;
    endcase
  end

  logic step_q;
  assign m_start = step_q;

  rfce_mac u_mac (
    .clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b), .fin_o(m_fin), .p_o(m_p)
  );

  rfce_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({nmag, 16'd0}), .den_i({2'd0, dmag}),
    .fin_o(div_fin), .quo_o(quo)
  );

  assign div_start = (state_q == StDen);
  assign in_if.ready = (state_q == StIdle) && !(out_valid_q && last_q);
  assign out_if.valid     = out_valid_q;
  assign out_if.cost      = res_q.cost;
  assign out_if.improved  = res_q.improved;
  assign out_if.done_res  = res_q.done_res;
  assign out_if.saturated = res_q.saturated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= 1'b0;
      out_valid_q <= 1'b0;
      err_sum_q   <= '0;
      best_q      <= Max63;
      done_q      <= 1'b0;
      sat_q       <= 1'b0;
      limit_q     <= '0;
      last_q      <= 1'b0;
      for (int i = 0; i < CoeffCount; i++) begin
        coef_q[i]      <= '0;
        best_coef_q[i] <= '0;
      end
      coef_q[RegDenConst] <= 32'sd65536;
    end else begin
      step_q <= 1'b0;
      if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegPrecision) limit_q <= cfg_data_i;
        else if (cfg_idx_i < RegPrecision) coef_q[cfg_idx_i] <= cfg_data_i[31:0];
      end
      case (state_q)
        StIdle: if (in_if.valid && in_if.ready) begin
          x_q     <= in_if.sample_x;
          y_q     <= in_if.sample_y;
          last_q  <= in_if.last_sample;
          step_q  <= 1'b1;
          state_q <= StXsq;
        end
        StXsq: if (m_fin) begin
          xsq_q <= 47'(m_p >>> 16);
          step_q <= 1'b1; state_q <= StB1x;
        end
        StB1x: if (m_fin) begin
          num_q <= 50'(coef_q[RegNumConst]) + 50'(fl16);
          step_q <= 1'b1; state_q <= StA1x;
        end
        StA1x: if (m_fin) begin
          den_q <= 64'(coef_q[RegDenConst]) + fl16;
          step_q <= 1'b1; state_q <= StA2hi;
        end
        StA2hi: if (m_fin) begin
          den_q <= den_q + m_p;
          step_q <= 1'b1; state_q <= StA2lo;
        end
        StA2lo: if (m_fin) begin
          den_q <= den_q + fl16;
          state_q <= StDen;
        end
        StDen: begin
          if (den_q == '0) begin
            err_sum_q <= Max63; sat_q <= 1'b1; state_q <= StAcc;
          end else state_q <= StDiv;
        end
        StDiv: if (div_fin) begin
          // quotient magnitude beyond 2^40 saturates
          if (quo > DivNumW'(64'd1 << 40)) begin
            err_sum_q <= Max63; sat_q <= 1'b1; state_q <= StAcc;
          end else begin
            err_q <= 64'(y_q) - ((num_q[49] ^ den_q[63]) ? -64'(quo) : 64'(quo));
            state_q <= StErr;
          end
        end
        StErr: begin
          if (emag[63:32] != '0) begin
            err_sum_q <= Max63; sat_q <= 1'b1; state_q <= StAcc;
          end else begin
            err_q <= $signed(emag); step_q <= 1'b1; state_q <= StSq;
          end
        end
        StSq: if (m_fin) begin
          sq_q <= m_p;
          state_q <= StRes;
        end
        StRes: begin
          // add and saturate; sq_q needs unsigned view (|err|<2^32)
          if (sq_q[63] || sum[63]) begin
            err_sum_q <= Max63; sat_q <= 1'b1;
          end else err_sum_q <= sum[62:0];
          state_q <= StAcc;
        end
        StAcc: begin
          if (!last_q) state_q <= StIdle;
          else if (!out_valid_q || out_if.ready) begin
            res_q.cost      <= err_sum_q;
            res_q.improved  <= err_sum_q < best_q;
            res_q.done_res  <= done_q || ((err_sum_q < best_q) && (err_sum_q < limit_q));
            res_q.saturated <= sat_q;
            if (err_sum_q < best_q) begin
              best_q <= err_sum_q;
              for (int i = 0; i < CoeffCount; i++) best_coef_q[i] <= coef_q[i];
              if (err_sum_q < limit_q) done_q <= 1'b1;
            end
            out_valid_q <= 1'b1;
            err_sum_q   <= '0;
            sat_q       <= 1'b0;
            last_q      <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== sim/tb_rational_fit_cost_evaluator_top.sv =====
module tb_rational_fit_cost_evaluator_top;
  import rfce_pkg::*;

  // Indexes past the register list; writes there must leave every register alone.
  localparam logic [CfgIdxW-1:0] RegBeyondLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBeyondHi = 3'd7;
  localparam int unsigned SampleCount  = 850;
  // Longest a sample may still be in flight once the last result word is out.
  localparam int unsigned SettleCycles = 250;

  typedef enum logic { RowSample, RowWrite } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CfgIdxW-1:0] idx;
    logic [62:0]       data;
    logic [31:0]       x;
    logic [31:0]       y;
    logic              last;
    logic              typed;
    rfce_res_t         want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rfce_in_if  smp_bus ();
  rfce_out_if res_bus ();

  rational_fit_cost_evaluator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (smp_bus),
    .out_if     (res_bus)
  );

  // Shadow of the candidate registers and of the search state.
  logic signed [31:0] coef_q [CoeffCount];
  logic [62:0]        limit_q;
  logic [62:0]        run_sum;
  logic [62:0]        best_cost;
  logic               search_done;
  logic               sat_seen;

  rfce_res_t cost_q [$];
  int        fail_count;
  int        hold_off;
  bit        calm;
  dir_row_t  dir_tab [$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("rational_fit_cost_evaluator_top: mismatch");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("ERROR %s: got %h, want %h", what, got, want);
    fail_count++;
  endtask

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Fold one sample into the running squared-error sum.
  function automatic void fold_sample(input logic signed [31:0] x, input logic signed [31:0] y);
    longint sx = longint'(x);
    longint sy = longint'(y);
    longint b0 = longint'(coef_q[RegNumConst]);
    longint b1 = longint'(coef_q[RegNumLinear]);
    longint a2 = longint'(coef_q[RegDenSquare]);
    longint a1 = longint'(coef_q[RegDenLinear]);
    longint a0 = longint'(coef_q[RegDenConst]);
    longint unsigned xsq, qmag, emag, sq, total;
    longint hi, lo, num, den, quo, err;
    xsq = longint'(sx * sx) >> 16;
    hi  = longint'(xsq >> 16);
    lo  = longint'(xsq & 64'hFFFF);
    num = b0 + ((b1 * sx) >>> 16);
    den = a0 + ((a1 * sx) >>> 16) + a2 * hi + ((a2 * lo) >>> 16);
    if (den == 0) begin
      run_sum = Max63;
      sat_seen = 1'b1;
      return;
    end
    qmag = (magnitude(num) << 16) / magnitude(den);
    if (qmag > (64'd1 << 40)) begin
      run_sum = Max63;
      sat_seen = 1'b1;
      return;
    end
    quo  = ((num < 0) != (den < 0)) ? -longint'(qmag) : longint'(qmag);
    err  = sy - quo;
    emag = magnitude(err);
    if (emag >= (64'd1 << 32)) begin
      run_sum = Max63;
      sat_seen = 1'b1;
      return;
    end
    sq    = emag * emag;
    total = {1'b0, run_sum} + sq;
    if (sq > {1'b0, Max63} || total > {1'b0, Max63}) begin
      run_sum = Max63;
      sat_seen = 1'b1;
      return;
    end
    run_sum = total[62:0];
  endfunction

  // Close the data set: score it against the best so far and clear the sum.
  function automatic rfce_res_t close_set();
    rfce_res_t r;
    r.cost     = run_sum;
    r.improved = run_sum < best_cost;
    if (r.improved) begin
      best_cost = run_sum;
      if (run_sum < limit_q) search_done = 1'b1;
    end
    r.done_res  = search_done;
    r.saturated = sat_seen;
    run_sum  = '0;
    sat_seen = 1'b0;
    return r;
  endfunction

  // Drive one sample word; returns once it is accepted.
  task automatic send_sample(input logic [31:0] x, input logic [31:0] y, input logic last,
                             input logic typed, input rfce_res_t want);
    rfce_res_t got;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 18) begin
      smp_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    smp_bus.valid       = 1'b1;
    smp_bus.sample_x    = x;
    smp_bus.sample_y    = y;
    smp_bus.last_sample = last;
    do @(posedge clk_i); while (!smp_bus.ready);
    fold_sample(x, y);
    if (last) begin
      got = close_set();
      if (typed && got !== want) report("typed expectation", {1'b0, got.cost}, {1'b0, want.cost});
      cost_q.push_back(got);
    end
  endtask

  // Drop valid, wait for every result word, then let any trailing sample finish.
  task automatic settle();
    @(negedge clk_i);
    smp_bus.valid = 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [62:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    if (idx < CoeffCount) coef_q[idx] = data[31:0];
    else if (idx == RegPrecision) limit_q = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly small values near the interesting range, sometimes full width or extremes.
  function automatic logic [31:0] pick_word(input int unsigned spread);
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2 * spread)) - $signed(spread));
    endcase
  endfunction

  function automatic logic [62:0] pick_limit();
    case ($urandom_range(4))
      0:       return '0;
      1:       return Max63;
      2:       return 63'({$urandom, $urandom});
      default: return 63'($urandom) << $urandom_range(8, 30);
    endcase
  endfunction

  task automatic retune();
    settle();
    write_reg(RegNumConst,  63'({$urandom, pick_word(1 << 18)}));
    write_reg(RegNumLinear, 63'({$urandom, pick_word(1 << 16)}));
    write_reg(RegDenSquare, 63'({$urandom, pick_word(1 << 10)}));
    write_reg(RegDenLinear, 63'({$urandom, pick_word(1 << 12)}));
    write_reg(RegDenConst,  63'({$urandom, 32'(65536 + $signed(pick_word(1 << 14)))}));
    if ($urandom_range(3) == 0) write_reg(RegPrecision, pick_limit());
  endtask

  // Result side: check at the rising edge, decide ready at the falling edge.
  initial begin
    rfce_res_t want;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) begin
        if (cost_q.size() == 0) begin
          report("unexpected result word", {1'b0, res_bus.cost}, '0);
        end else begin
          want = cost_q.pop_front();
          if (res_bus.cost !== want.cost) report("cost", {1'b0, res_bus.cost}, {1'b0, want.cost});
          if (res_bus.improved !== want.improved)
            report("improved", 64'(res_bus.improved), 64'(want.improved));
          if (res_bus.done_res !== want.done_res)
            report("done_res", 64'(res_bus.done_res), 64'(want.done_res));
          if (res_bus.saturated !== want.saturated)
            report("saturated", 64'(res_bus.saturated), 64'(want.saturated));
        end
      end
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        res_bus.ready = 1'b0;
      end else begin
        res_bus.ready = calm || $urandom_range(99) >= 18;
      end
    end
  end

  initial begin
    rfce_res_t none;
    int sent, len;
    bit pressed;
    none = '0;
    fail_count = 0;
    hold_off = 0;
    calm = 1'b0;
    pressed = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    smp_bus.valid = 1'b0;
    smp_bus.sample_x = '0;
    smp_bus.sample_y = '0;
    smp_bus.last_sample = 1'b0;
    for (int i = 0; i < CoeffCount; i++) coef_q[i] = '0;
    coef_q[RegDenConst] = 32'd65536;
    limit_q = '0;
    run_sum = '0;
    best_cost = Max63;
    search_done = 1'b0;
    sat_seen = 1'b0;

    // Directed part: zero-output reset model first, then the corner cases.
    dir_tab = '{
      '{RowSample, '0, '0, 32'h0, 32'h1, 1'b1, 1'b1, '{63'd1, 1'b1, 1'b0, 1'b0}},
      '{RowSample, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
        '{63'h4000_0000_0000_0000, 1'b0, 1'b0, 1'b0}},
      '{RowSample, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h0, 32'h8000_0000, 1'b1, 1'b0, none},
      // Two full-scale errors overflow the sum.
      '{RowSample, '0, '0, 32'h1234, 32'h8000_0000, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h0, 32'h8000_0000, 1'b1, 1'b1, '{Max63, 1'b0, 1'b0, 1'b1}},
      '{RowWrite, RegPrecision, Max63, '0, '0, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h0003_0000, 32'h0, 1'b1, 1'b1, '{63'd0, 1'b1, 1'b1, 1'b0}},
      // Zero denominator.
      '{RowWrite, RegDenConst, 63'd0, '0, '0, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h5, 32'h5, 1'b1, 1'b1, '{Max63, 1'b0, 1'b1, 1'b1}},
      // Huge quotient.
      '{RowWrite, RegDenConst, 63'd1, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegNumConst, 63'h7FFF_FFFF, '0, '0, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h0, 32'h0, 1'b1, 1'b1, '{Max63, 1'b0, 1'b1, 1'b1}},
      '{RowWrite, RegNumConst, 63'h8000_0000, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegNumLinear, 63'h7FFF_FFFF, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegDenSquare, 63'h8000_0000, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegDenLinear, 63'h7FFF_FFFF, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegDenConst, 63'h7FFF_FFFF, '0, '0, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h8000_0000, 32'h0, 1'b1, 1'b0, none},
      '{RowWrite, RegNumLinear, 63'h8000_0000, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegDenSquare, 63'h7FFF_FFFF, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegDenLinear, 63'h8000_0000, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegDenConst, 63'h8000_0000, '0, '0, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b0, none},
      '{RowSample, '0, '0, 32'hFFFF_8000, 32'h0000_8000, 1'b1, 1'b0, none},
      // Writes past the list are dropped; the next sample shows the same model.
      '{RowWrite, RegBeyondLo, Max63, '0, '0, 1'b0, 1'b0, none},
      '{RowWrite, RegBeyondHi, 63'h0, '0, '0, 1'b0, 1'b0, none},
      '{RowSample, '0, '0, 32'h0002_0000, 32'h0001_0000, 1'b1, 1'b0, none},
      '{RowWrite, RegPrecision, 63'd0, '0, '0, 1'b0, 1'b0, none}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowWrite) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_sample(dir_tab[i].x, dir_tab[i].y, dir_tab[i].last, dir_tab[i].typed,
                    dir_tab[i].want);
        sent++;
      end
    end

    // Random part: data sets of random length under a tuned candidate.
    retune();
    while (sent < SampleCount) begin
      calm = (sent >= 250 && sent < 380);
      if ($urandom_range(24) == 0) retune();
      if (!pressed && sent >= 500) begin
        // Hold the result side off while one-sample sets keep arriving.
        pressed = 1'b1;
        hold_off = 3000;
        repeat (12) begin
          send_sample(pick_word(1 << 20), pick_word(1 << 20), 1'b1, 1'b0, none);
          sent++;
        end
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      for (int k = 1; k <= len; k++) begin
        send_sample(pick_word(1 << 20), pick_word(1 << 20), k == len, 1'b0, none);
        sent++;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("rational_fit_cost_evaluator_top: match");
    end else begin
      $display("rational_fit_cost_evaluator_top: mismatch");
    end
    $finish;
  end

endmodule
